/* design/kec_pkg.sv */
// shared types, constants and constant tables for the kepler cordic solver
// depends on nothing; used by every module of the block
package kec_pkg;

    localparam int MW = 32;
    localparam int EW = 34;
    localparam int CW = 33;
    localparam int KW = 31;
    localparam int GW = 31;

    localparam logic signed [EW-1:0] PI_Q28      = 34'sh03243F6A9;
    localparam logic signed [EW-1:0] TWO_PI_Q28  = 34'sh06487ED51;
    localparam logic signed [EW-1:0] HALF_PI_Q28 = 34'sh01921FB54;
    localparam logic signed [CW-1:0] ONE_Q30     = 33'sh040000000;

    localparam logic REG_ECC  = 1'b0;
    localparam logic REG_ITER = 1'b1;

    typedef struct packed {
        logic signed [EW-1:0] e_acc;
        logic signed [CW-1:0] cs;
        logic signed [CW-1:0] sn;
        logic signed [MW-1:0] m;
    } stage_t;

    typedef logic [51:0] frac_tbl_t [27];

    localparam frac_tbl_t ATAN_FRAC = '{
        52'h921fb54442d18, 52'hdac670561bb4f, 52'hf5b75f92c80dd,
        52'hfd5ba9aac2f6e, 52'hff55bb72cfdea, 52'hffd55bba97625,
        52'hfff555bbb729b, 52'hfffd555bbba97, 52'hffff5555bbbb7,
        52'hffffd5555bbbc, 52'hfffff55555bbc, 52'hfffffd55555bc,
        52'hffffff555555c, 52'hffffffd555556, 52'hfffffff555555,
        52'hfffffffd55555, 52'hffffffff55555, 52'hffffffffd5555,
        52'hfffffffff5555, 52'hfffffffffd555, 52'hffffffffff555,
        52'hffffffffffd55, 52'hfffffffffff55, 52'hfffffffffffd5,
        52'hffffffffffff5, 52'hffffffffffffd, 52'hfffffffffffff
    };

    localparam frac_tbl_t GAIN_FRAC = '{
        52'h0,
        52'h6a09e667f3bcc, 52'h43d136248490e, 52'h3a261ba6d7a36,
        52'h37b9141deb3fe, 52'h371dac182eef5, 52'h36f6cfabd961f,
        52'h36ed1869f27e9, 52'h36eaaa970b20f, 52'h36ea0f222a6d1,
        52'h36e9e844efd24, 52'h36e9de8da104b, 52'h36e9dc1fcd4ee,
        52'h36e9db8458614, 52'h36e9db5d7b25d, 52'h36e9db53c3d6f,
        52'h36e9db5156034, 52'h36e9db50ba8e5, 52'h36e9db5093b11,
        52'h36e9db5089f9c, 52'h36e9db50878bf, 52'h36e9db5086f08,
        52'h36e9db5086c9a, 52'h36e9db5086bff, 52'h36e9db5086bd8,
        52'h36e9db5086bce, 52'h36e9db5086bcc
    };

    function automatic logic [63:0] round_shift(logic [63:0] v, int sh);
        logic [63:0] r;
        if (sh == 0)
        begin
            r = v;
        end
        else if (sh >= 54)
        begin
            r = '0;
        end
        else
        begin
            r = (v + (64'd1 << (sh - 1))) >> sh;
        end
        return r;
    endfunction

    function automatic logic [63:0] atan_q28(int n);
        logic [63:0] r;
        if (n <= 26)
        begin
            r = round_shift({11'd1, ATAN_FRAC[n]}, 25 + n);
        end
        else
        begin
            r = round_shift(64'h0010000000000000, 24 + n);
        end
        return r;
    endfunction

    function automatic logic [63:0] gain_q30(int n);
        logic [63:0] r;
        int k;
        k = (n > 26) ? 26 : n;
        if (n == 0)
        begin
            r = 64'h40000000;
        end
        else
        begin
            r = round_shift({11'd1, GAIN_FRAC[k]}, 23);
        end
        return r;
    endfunction

endpackage

/* design/kepler_equation_cordic_solver_core.sv */
// top level: apb configuration registers, range reduction and the rotation pipeline
// depends on kec_pkg, kec_reduce, kec_stage
// A request enters on any cycle with start high; busy is always low, so a new
// mean anomaly can be issued every clock. Each request gives one result on
// eccentric_anomaly, flagged by done for one cycle, after passing through
// one stage of range reduction and one pipeline stage per rotation,
// stages beyond iteration_count passing the value through. Results come in
// request order and cannot be held off by the receiver.
module kepler_equation_cordic_solver_core #(
    parameter int MAX_ITERATIONS = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [kec_pkg::MW-1:0]  mean_anomaly,
    output logic                           done,
    output logic signed [kec_pkg::EW-1:0]  eccentric_anomaly
);
    import kec_pkg::*;

    logic [KW-1:0] ecc_reg;
    logic [5:0]    iter_reg;
    logic          wr;
    logic          vld [MAX_ITERATIONS+1];
    stage_t        stg [MAX_ITERATIONS+1];

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecc_reg  <= '0;
            iter_reg <= 6'd29;
        end
        else if (wr)
        begin
            unique case (paddr[2])
                REG_ECC:  ecc_reg  <= pwdata[KW-1:0];
                REG_ITER: iter_reg <= pwdata[5:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ECC:  prdata = {1'b0, ecc_reg};
            REG_ITER: prdata = {26'd0, iter_reg};
            default:  prdata = '0;
        endcase
    end

    kec_reduce u_reduce (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .mean_anomaly (mean_anomaly),
        .out_valid    (vld[0]),
        .out_s        (stg[0])
    );

    for (genvar i = 0; i < MAX_ITERATIONS; i++)
    begin : g_stage
        kec_stage #(.N(i)) u_stage (
            .clk          (clk),
            .rst_n        (rst_n),
            .eccentricity (ecc_reg),
            .active       (32'(iter_reg) > i),
            .in_valid     (vld[i]),
            .in_s         (stg[i]),
            .out_valid    (vld[i+1]),
            .out_s        (stg[i+1])
        );
    end

    assign done              = vld[MAX_ITERATIONS];
    assign eccentric_anomaly = stg[MAX_ITERATIONS].e_acc;

endmodule

/* design/kec_reduce.sv */
// range reduction and quarter-turn start, one register stage
// depends on kec_pkg
module kec_reduce (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic signed [kec_pkg::MW-1:0] mean_anomaly,
    output logic                         out_valid,
    output kec_pkg::stage_t              out_s
);
    import kec_pkg::*;

    logic signed [EW-1:0] m_ext;
    logic signed [EW-1:0] base;
    logic                 valid_reg;
    stage_t               s_reg;
    stage_t               s_next;

    assign m_ext = EW'(mean_anomaly);

    always_comb
    begin
        if (m_ext >= PI_Q28)
        begin
            base = TWO_PI_Q28;
        end
        else if (m_ext <= -PI_Q28)
        begin
            base = -TWO_PI_Q28;
        end
        else
        begin
            base = '0;
        end
        s_next.m  = mean_anomaly;
        s_next.cs = '0;
        if (base > m_ext)
        begin
            s_next.sn    = -ONE_Q30;
            s_next.e_acc = base - HALF_PI_Q28;
        end
        else
        begin
            s_next.sn    = ONE_Q30;
            s_next.e_acc = base + HALF_PI_Q28;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;

endmodule

/* design/kec_stage.sv */
// one cordic rotation step with its own gain-scaled eccentricity register
// depends on kec_pkg
module kec_stage #(
    parameter int N = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kec_pkg::KW-1:0]        eccentricity,
    input  logic                          active,
    input  logic                          in_valid,
    input  kec_pkg::stage_t               in_s,
    output logic                          out_valid,
    output kec_pkg::stage_t               out_s
);
    import kec_pkg::*;

    localparam logic [63:0] ATAN64 = atan_q28(N);
    localparam logic [63:0] GAIN64 = gain_q30(N);
    localparam logic signed [EW-1:0] ATAN = EW'(ATAN64);
    localparam logic [GW-1:0] GAIN = GW'(GAIN64);

    logic [KW-1:0]         ek_reg;
    logic [KW-1:0]         ek_next;
    logic [KW+GW-1:0]      ek_prod;
    logic [CW-1:0]         mag;
    logic [63:0]           prod;
    logic [CW-1:0]         p;
    logic signed [CW-1:0]  t;
    logic signed [EW:0]    diff;
    logic signed [CW-1:0]  ds;
    logic signed [CW-1:0]  dc;
    logic                  valid_reg;
    stage_t                s_reg;
    stage_t                s_next;

    assign ek_prod = {{GW{1'b0}}, eccentricity} * {{KW{1'b0}}, GAIN}
                   + (KW+GW)'(64'd1 << 29);
    assign ek_next = ek_prod[30 +: KW];

    always_comb
    begin
        mag  = in_s.sn[CW-1] ? CW'(-in_s.sn) : CW'(in_s.sn);
        prod = 64'(ek_reg) * 64'(mag) + (64'd1 << 31);
        p    = CW'(prod >> 32);
        t    = in_s.sn[CW-1] ? -$signed(p) : $signed(p);
        diff = (EW+1)'(in_s.e_acc) - (EW+1)'(t);
        ds   = in_s.sn >>> N;
        dc   = in_s.cs >>> N;
        s_next = in_s;
        if (active)
        begin
            if (diff > (EW+1)'(in_s.m))
            begin
                s_next.e_acc = in_s.e_acc - ATAN;
                s_next.cs    = in_s.cs + ds;
                s_next.sn    = in_s.sn - dc;
            end
            else
            begin
                s_next.e_acc = in_s.e_acc + ATAN;
                s_next.cs    = in_s.cs - ds;
                s_next.sn    = in_s.sn + dc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ek_reg <= ek_next;
        s_reg  <= s_next;
    end

    assign out_valid = valid_reg;
    assign out_s     = s_reg;

endmodule

/* test/testbench.sv */
// self-checking bench for kepler_equation_cordic_solver_core: apb setup, directed table, random
// depends on kec_pkg and the core; its own fixed-point solver predicts results the table lacks
module testbench;
    import kec_pkg::*;

    localparam int MAXIT = 32;
    localparam int LAT = MAXIT + 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        logic [30:0]          ecc;
        logic [5:0]           iters;
        logic signed [MW-1:0] m;
        bit                   known;
        logic signed [EW-1:0] e_known;
    } row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [2:0]           paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 start;
    logic                 busy;
    logic signed [MW-1:0] mean_anomaly;
    logic                 done;
    logic signed [EW-1:0] eccentric_anomaly;

    logic [30:0]          ecc_cfg;
    logic [5:0]           iter_cfg;
    logic signed [EW-1:0] anomaly_q[$];
    bit                   known_q[$];
    logic signed [EW-1:0] known_val_q[$];
    int                   errors;
    int                   cycles;
    int                   requests;
    int                   results;
    bit                   busy_runs;
    row_t                 rows[$];

    kepler_equation_cordic_solver_core #(.MAX_ITERATIONS(MAXIT)) u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .mean_anomaly(mean_anomaly), .done(done),
        .eccentric_anomaly(eccentric_anomaly)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [63:0] rnd_shr(logic [63:0] v, int sh);
        if (sh == 0)
        begin
            return v;
        end
        if (sh >= 54)
        begin
            return 64'd0;
        end
        return (v + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic longint arctan_step(int n);
        if (n <= 26)
        begin
            return longint'(rnd_shr({12'd1, ATAN_FRAC[n]}, 25 + n));
        end
        return longint'(rnd_shr(64'd1 << 52, 24 + n));
    endfunction

    function automatic logic [63:0] gain_step(int n);
        if (n == 0)
        begin
            return 64'h40000000;
        end
        return rnd_shr({12'd1, GAIN_FRAC[(n > 26) ? 26 : n]}, 23);
    endfunction

    function automatic logic signed [EW-1:0] solve_kepler(logic signed [MW-1:0] m);
        longint ma;
        longint e;
        longint c;
        longint s;
        longint t;
        longint ds;
        longint dc;
        logic [63:0] ek;
        logic [63:0] mag;
        logic [63:0] p;
        int steps;
        ma = m;
        if (ma >= longint'(PI_Q28))
        begin
            e = TWO_PI_Q28;
        end
        else if (ma <= -longint'(PI_Q28))
        begin
            e = -longint'(TWO_PI_Q28);
        end
        else
        begin
            e = 0;
        end
        c = 0;
        if (e > ma)
        begin
            s = -longint'(ONE_Q30);
            e = e - longint'(HALF_PI_Q28);
        end
        else
        begin
            s = ONE_Q30;
            e = e + longint'(HALF_PI_Q28);
        end
        steps = (iter_cfg > MAXIT) ? MAXIT : iter_cfg;
        for (int n = 0; n < steps; n++)
        begin
            ek = ({33'd0, ecc_cfg} * gain_step(n) + (64'd1 << 29)) >> 30;
            mag = (s < 0) ? 64'(-s) : 64'(s);
            p = (ek * mag + (64'd1 << 31)) >> 32;
            t = (s < 0) ? -longint'(p) : longint'(p);
            ds = s >>> n;
            dc = c >>> n;
            if (e - t > ma)
            begin
                e = e - arctan_step(n);
                c = c + ds;
                s = s - dc;
            end
            else
            begin
                e = e + arctan_step(n);
                c = c - ds;
                s = s + dc;
            end
        end
        return e[EW-1:0];
    endfunction

    task automatic report_mismatch(string what, logic signed [EW-1:0] want,
                                   logic signed [EW-1:0] got);
        $display("mismatch %0s at cycle %0d: expected %0d got %0d", what, cycles, want, got);
        errors++;
    endtask

    // request bookkeeping and result checking
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (busy)
        begin
            busy_runs <= 1'b1;
        end
        if (rst_n && start && !busy)
        begin
            requests <= requests + 1;
            if (known_q.size() != 0 && known_q.pop_front())
            begin
                anomaly_q.push_back(known_val_q.pop_front());
            end
            else
            begin
                if (known_val_q.size() != 0)
                begin
                    known_val_q.delete(0);
                end
                anomaly_q.push_back(solve_kepler(mean_anomaly));
            end
        end
        if (rst_n && done)
        begin
            results <= results + 1;
            if (anomaly_q.size() == 0)
            begin
                report_mismatch("unexpected result", '0, eccentric_anomaly);
            end
            else
            begin
                logic signed [EW-1:0] want;
                want = anomaly_q.pop_front();
                if (eccentric_anomaly !== want)
                begin
                    report_mismatch("eccentric_anomaly", want, eccentric_anomaly);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", anomaly_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic apb_write(logic idx, logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ECC)
        begin
            ecc_cfg = val[30:0];
        end
        else
        begin
            iter_cfg = val[5:0];
        end
        @(negedge clk);
    endtask

    task automatic drain_pipe();
        while (anomaly_q.size() != 0 || known_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LAT + 4) @(negedge clk);
    endtask

    task automatic set_config(logic [30:0] ecc, logic [5:0] iters);
        if (ecc != ecc_cfg || iters != iter_cfg)
        begin
            start <= 1'b0;
            drain_pipe();
            apb_write(REG_ECC, {1'b0, ecc});
            apb_write(REG_ITER, {26'd0, iters});
        end
    endtask

    task automatic send_request(logic signed [MW-1:0] m, bit known,
                                logic signed [EW-1:0] e_known, bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        mean_anomaly <= m;
        known_q.push_back(known);
        known_val_q.push_back(e_known);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    function automatic logic signed [MW-1:0] rand_anomaly();
        logic signed [MW-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = PI_Q28[MW-1:0] + $signed($urandom_range(0, 8)) - 4;
            2: v = -PI_Q28[MW-1:0] + $signed($urandom_range(0, 8)) - 4;
            default: v = $signed($urandom_range(0, 32'h3243F6A9 * 2)) - PI_Q28[MW-1:0];
        endcase
        return v;
    endfunction

    function automatic row_t mk(logic [30:0] ecc, logic [5:0] iters, logic signed [MW-1:0] m,
                                bit known, logic signed [EW-1:0] e_known);
        row_t r;
        r.ecc = ecc;
        r.iters = iters;
        r.m = m;
        r.known = known;
        r.e_known = e_known;
        return r;
    endfunction

    initial
    begin
        logic [30:0] ecc_sel;
        logic [5:0]  iter_sel;
        bit          no_gaps;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        mean_anomaly = '0;
        errors = 0;
        cycles = 0;
        requests = 0;
        results = 0;
        busy_runs = 1'b0;
        ecc_cfg = '0;
        iter_cfg = 6'd29;

        // zero iterations give the reduced start angle directly
        rows.push_back(mk(31'd0, 6'd0, 32'sd0, 1, 34'sh01921FB54));
        rows.push_back(mk(31'd0, 6'd0, -32'sd1, 1, -34'sh01921FB54));
        rows.push_back(mk(31'd0, 6'd0, 32'sh3243F6A9, 1, 34'sh04B65F1FD));
        rows.push_back(mk(31'd0, 6'd0, -32'sh3243F6A9, 1, -34'sh04B65F1FD));
        rows.push_back(mk(31'd0, 6'd0, 32'sh7FFFFFFF, 1, 34'sh07DA9E8A5));
        rows.push_back(mk(31'd0, 6'd0, 32'sh80000000, 1, -34'sh07DA9E8A5));
        // reset settings
        rows.push_back(mk(31'd0, 6'd29, 32'sd0, 0, '0));
        rows.push_back(mk(31'd0, 6'd29, 32'sh3243F6A8, 0, '0));
        rows.push_back(mk(31'd0, 6'd29, 32'sh7FFFFFFF, 0, '0));
        rows.push_back(mk(31'd0, 6'd29, 32'sh80000000, 0, '0));
        // e = 1, full and single iteration
        rows.push_back(mk(31'h40000000, 6'd32, 32'sd0, 0, '0));
        rows.push_back(mk(31'h40000000, 6'd32, 32'sh10000000, 0, '0));
        rows.push_back(mk(31'h40000000, 6'd32, -32'sh3243F6A9, 0, '0));
        rows.push_back(mk(31'h40000000, 6'd1, 32'sh20000000, 0, '0));
        // eccentricity register above one, count above the pipeline depth; then two mixed rows
        rows.push_back(mk(31'h7FFFFFFF, 6'd63, 32'sh7FFFFFFF, 0, '0));
        rows.push_back(mk(31'h7FFFFFFF, 6'd63, 32'sh80000000, 0, '0));
        rows.push_back(mk(31'h7FFFFFFF, 6'd33, -32'sh00000001, 0, '0));
        rows.push_back(mk(31'h2AAAAAAA, 6'd16, 32'sh55555555, 0, '0));
        rows.push_back(mk(31'h15555555, 6'd42, 32'shAAAAAAAA, 0, '0));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            set_config(rows[i].ecc, rows[i].iters);
            send_request(rows[i].m, rows[i].known, rows[i].e_known, 1'b0);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 175 == 0)
            begin
                case ((i / 175) % 4)
                    0: ecc_sel = 31'h40000000;
                    1: ecc_sel = 31'd0;
                    2: ecc_sel = 31'h7FFFFFFF;
                    default: ecc_sel = 31'($urandom_range(0, 32'h40000000));
                endcase
                case ($urandom_range(0, 4))
                    0: iter_sel = 6'd32;
                    1: iter_sel = 6'd1;
                    2: iter_sel = 6'd63;
                    3: iter_sel = 6'd29;
                    default: iter_sel = 6'($urandom_range(0, 63));
                endcase
                set_config(ecc_sel, iter_sel);
            end
            if (i % 40 == 0)
            begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            send_request(rand_anomaly(), 0, '0, no_gaps);
        end
        start <= 1'b0;

        while (anomaly_q.size() != 0 || known_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (LAT + 8) @(negedge clk);

        $display("%0d requests, %0d results checked over several eccentricity/iteration settings",
                 requests, results);
        $display("busy seen high: %0d, mismatches: %0d", busy_runs, errors);
        if (errors == 0 && anomaly_q.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
